FILE: src/sia_pkg.sv
package sia_pkg;

	localparam int SLOT_COUNT = 256;
	localparam int ID_W       = 8;
	localparam int COUNT_W    = $clog2(SLOT_COUNT + 1);
	localparam int MARK_W     = COUNT_W;

	localparam logic [MARK_W-1:0] MARK_NONE = '1;

	typedef logic [1:0] op_t;
	typedef logic [1:0] status_t;

	localparam op_t OP_ALLOC   = 2'd0;
	localparam op_t OP_RELEASE = 2'd1;
	localparam op_t OP_COMPACT = 2'd2;
	localparam op_t OP_CLEAR   = 2'd3;

	localparam status_t STATUS_OK       = 2'd0;
	localparam status_t STATUS_EMPTY    = 2'd1;
	localparam status_t STATUS_ABOVE    = 2'd2;
	localparam status_t STATUS_OVERFLOW = 2'd3;

	// shared controls for the whole cell row
	typedef struct packed {
		logic push;
		logic pop;
		logic sort_en;
		logic phase;
	} chain_ctl_t;

	// per-cell controls
	typedef struct packed {
		logic push;
		logic pop;
		logic sort_lo;
		logic sort_hi;
	} cell_ctl_t;

endpackage

FILE: src/slot_id_allocator.sv
// Slot id allocator. Freed ids live in a row of cells that acts as a LIFO
// stack (cell 0 is the top; push and pop shift the whole row by one). New ids
// come from a high-water mark once the stack is empty. Allocate, release and
// release-all can be issued back to back while the registered result is taken.
// Compact runs an odd-even transposition sort over the occupied cells, then
// pops one id per cycle while the top equals the mark, and then posts the
// result; input is held off during that time.
module slot_id_allocator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  sia_pkg::op_t                op,
	input  logic [sia_pkg::ID_W-1:0]    slot_id,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [sia_pkg::ID_W-1:0]    granted_id,
	output sia_pkg::status_t            status
);
	import sia_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SORT = 2'd1;
	localparam logic [1:0] ST_POP  = 2'd2;

	logic [1:0]         state_q, state_d;
	logic [COUNT_W-1:0] count_q, count_d;
	logic [MARK_W-1:0]  mark_q, mark_d;
	logic [COUNT_W-1:0] round_q, round_d;
	logic               out_valid_q;
	logic [ID_W-1:0]    granted_q, res_id;
	status_t            status_q, res_st;
	logic               res_load;
	logic               accept;
	logic [MARK_W-1:0]  mark_inc;
	logic [MARK_W-1:0]  id_ext;
	logic [ID_W-1:0]    top_val;
	chain_ctl_t         ctl;

	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;
	assign mark_inc = mark_q + 1'b1;
	assign id_ext   = MARK_W'(slot_id);

	always_comb begin
		ctl      = '0;
		count_d  = count_q;
		mark_d   = mark_q;
		round_d  = round_q;
		state_d  = state_q;
		res_id   = '0;
		res_st   = STATUS_OK;
		res_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (op)
						OP_ALLOC: begin
							res_load = 1'b1;
							if (count_q != '0) begin
								ctl.pop = 1'b1;
								count_d = count_q - 1'b1;
								res_id  = top_val;
							end else if (!mark_inc[MARK_W-1]) begin
								mark_d = mark_inc;
								res_id = mark_inc[ID_W-1:0];
							end else begin
								res_st = STATUS_EMPTY;
							end
						end
						OP_RELEASE: begin
							res_load = 1'b1;
							if (mark_q == MARK_NONE || id_ext > mark_q) begin
								res_st = STATUS_ABOVE;
							end else if (id_ext == mark_q) begin
								mark_d = mark_q - 1'b1;
							end else if (count_q == COUNT_W'(SLOT_COUNT)) begin
								res_st = STATUS_OVERFLOW;
							end else begin
								ctl.push = 1'b1;
								count_d  = count_q + 1'b1;
							end
						end
						OP_COMPACT: begin
							state_d = ST_SORT;
							round_d = '0;
						end
						OP_CLEAR: begin
							res_load = 1'b1;
							count_d  = '0;
							mark_d   = MARK_NONE;
						end
						default: ;
					endcase
				end
			end
			ST_SORT: begin
				if (round_q >= count_q) begin
					state_d = ST_POP;
				end else begin
					ctl.sort_en = 1'b1;
					ctl.phase   = round_q[0];
					round_d     = round_q + 1'b1;
				end
			end
			ST_POP: begin
				if (count_q != '0 && mark_q != MARK_NONE &&
					MARK_W'(top_val) == mark_q) begin
					ctl.pop = 1'b1;
					count_d = count_q - 1'b1;
					mark_d  = mark_q - 1'b1;
				end else begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			mark_q      <= MARK_NONE;
			round_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			mark_q  <= mark_d;
			round_q <= round_d;
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			granted_q <= res_id;
			status_q  <= res_st;
		end
	end

	sia_chain u_chain (
		.clk      (clk),
		.ctl      (ctl),
		.count    (count_q),
		.push_val (slot_id),
		.top_val  (top_val)
	);

	assign out_valid  = out_valid_q;
	assign granted_id = granted_q;
	assign status     = status_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(SLOT_COUNT))
		else $error("free count beyond slot count");

	a_mark_range: assert property (@(posedge clk) disable iff (!arst_n)
		mark_q == MARK_NONE || mark_q < MARK_W'(SLOT_COUNT))
		else $error("high mark out of range");

	a_busy_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !out_valid_q)
		else $error("result pending during compaction");

	a_round_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SORT |-> round_q <= count_q)
		else $error("sort round past stack depth");

	a_compact_ends_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_load && state_q == ST_POP |=> state_q == ST_IDLE && out_valid_q)
		else $error("compaction result not posted");

endmodule

FILE: src/sia_cell.sv
module sia_cell (
	input  logic                    clk,
	input  sia_pkg::cell_ctl_t      ctl,
	input  logic [sia_pkg::ID_W-1:0] up_val,
	input  logic [sia_pkg::ID_W-1:0] down_val,
	output logic [sia_pkg::ID_W-1:0] val
);
	import sia_pkg::*;

	logic [ID_W-1:0] val_q;

	// sort_lo: this cell and the one below form a pair, keep the larger here
	// sort_hi: this cell and the one above form a pair, keep the smaller here
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			val_q <= up_val;
		end else if (ctl.pop) begin
			val_q <= down_val;
		end else if (ctl.sort_lo) begin
			if (down_val > val_q) begin
				val_q <= down_val;
			end
		end else if (ctl.sort_hi) begin
			if (up_val < val_q) begin
				val_q <= up_val;
			end
		end
	end

	assign val = val_q;

endmodule

FILE: src/sia_chain.sv
module sia_chain (
	input  logic                        clk,
	input  sia_pkg::chain_ctl_t         ctl,
	input  logic [sia_pkg::COUNT_W-1:0] count,
	input  logic [sia_pkg::ID_W-1:0]    push_val,
	output logic [sia_pkg::ID_W-1:0]    top_val
);
	import sia_pkg::*;

	logic [ID_W-1:0] vals [SLOT_COUNT];

	for (genvar k = 0; k < SLOT_COUNT; k++) begin : g_cell
		localparam logic LO_PAR = 1'(k % 2);
		localparam logic HI_PAR = 1'((k + 1) % 2);
		cell_ctl_t       cctl;
		logic [ID_W-1:0] up_v;
		logic [ID_W-1:0] down_v;

		if (k == 0) begin : g_top
			assign up_v = push_val;
		end else begin : g_mid
			assign up_v = vals[k-1];
		end

		if (k == SLOT_COUNT - 1) begin : g_end
			assign down_v = '0;
		end else begin : g_inner
			assign down_v = vals[k+1];
		end

		assign cctl.push    = ctl.push;
		assign cctl.pop     = ctl.pop;
		assign cctl.sort_lo = ctl.sort_en && (ctl.phase == LO_PAR) &&
			(COUNT_W'(k + 1) < count);
		assign cctl.sort_hi = ctl.sort_en && (k != 0) && (ctl.phase == HI_PAR) &&
			(COUNT_W'(k) < count);

		sia_cell u_cell (
			.clk      (clk),
			.ctl      (cctl),
			.up_val   (up_v),
			.down_val (down_v),
			.val      (vals[k])
		);
	end

	assign top_val = vals[0];

endmodule
